FILE: rtl/ils_pkg.sv
// ils_pkg: shared types and constants for the indexed list store
// holds field widths, operation and error codes, and the cell control struct
// no dependencies
package ils_pkg;

    // default sizes of the list
    localparam int DEPTH_DEF      = 64;
    localparam int WORD_WIDTH_DEF = 32;

    // stream field widths
    localparam int OP_W   = 3;
    localparam int IDX_W  = 7;
    localparam int VAL_W  = 32;
    localparam int FIDX_W = 6;
    localparam int CNT_W  = 7;
    localparam int ERR_W  = 2;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_GET    = 3'd0,
        OP_SET    = 3'd1,
        OP_INSERT = 3'd2,
        OP_REMOVE = 3'd3,
        OP_FIND   = 3'd4
    } t_op;

    // error codes
    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_FULL  = 2'd2
    } t_err;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic exec;     // request in execution, refresh match flags
        logic set_en;   // overwrite the entry at the index
        logic ins_en;   // shift up from the index and place the word
        logic rem_en;   // shift down from the index
    } t_cell_ctl;

endpackage

FILE: rtl/ils_cell.sv
// ils_cell: one list position, holds a data word and its match flag
// trades words with its left and right neighbors on insert and remove
// depends on ils_pkg
module ils_cell import ils_pkg::*; #(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    parameter int CMPW       = IDX_W,
    parameter int POS        = 0
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [CMPW-1:0]       i_idx,
    input  logic [CMPW-1:0]       i_count,
    input  logic [WORD_WIDTH-1:0] i_value,
    input  logic [WORD_WIDTH-1:0] i_left,
    input  logic [WORD_WIDTH-1:0] i_right,
    output logic [WORD_WIDTH-1:0] o_entry,
    output logic                  o_hit,
    output logic [WORD_WIDTH-1:0] o_rd
);

    localparam logic [CMPW-1:0] MY_POS = CMPW'(POS);

    logic [WORD_WIDTH-1:0] r_entry;
    logic [WORD_WIDTH-1:0] n_entry;
    logic                  r_hit;
    logic                  at_idx;
    logic                  above_idx;
    logic                  in_list;

    // position relative to the request index and the fill level
    assign at_idx    = (MY_POS == i_idx);
    assign above_idx = (MY_POS > i_idx);
    assign in_list   = (MY_POS < i_count);

    // next word: write, take from the left on insert, from the right on remove
    always_comb begin
        n_entry = r_entry;
        if ((i_ctl.set_en || i_ctl.ins_en) && at_idx) begin
            n_entry = i_value;
        end else if (i_ctl.ins_en && above_idx) begin
            n_entry = i_left;
        end else if (i_ctl.rem_en && (at_idx || above_idx)) begin
            n_entry = i_right;
        end
    end

    // entry storage and key match against the contents before the update
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_ctl.exec) begin
            r_hit <= in_list && (r_entry == i_value);
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;
    assign o_rd    = at_idx ? r_entry : '0;

endmodule

FILE: rtl/ils_find.sv
// ils_find: lowest set position of the cell match vector
// isolates the lowest set bit with one add, then encodes the one-hot word
// depends on ils_pkg
module ils_find import ils_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic [DEPTH-1:0]         i_hit,
    output logic                     o_found,
    output logic [$clog2(DEPTH)-1:0] o_index
);

    localparam int IW = $clog2(DEPTH);

    logic [DEPTH-1:0] lowest;

    // two's complement trick keeps only the lowest set bit
    assign lowest  = i_hit & (~i_hit + DEPTH'(1));
    assign o_found = |i_hit;

    // one-hot to binary
    always_comb begin
        o_index = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (lowest[i]) begin
                o_index = o_index | IW'(i);
            end
        end
    end

endmodule

FILE: rtl/indexed_list_store.sv
// indexed_list_store: top level of the ordered list, a chain of ils_cell with ils_find
// depends on ils_pkg, ils_cell, ils_find
//
// An ordered list of up to DEPTH words, held one word per cell in a row of
// cells. Each request word carries an operation (get, set, insert or append,
// remove, find), an index and a value, and gives exactly one result word with
// the read word, find status and index, the entry count after the request and
// an error code. After acceptance a request passes through S_EXEC, where all
// cells shift, write and compare their keys at once, then S_FIND, which
// encodes the lowest matching cell and loads the output register at its end.
// A new request is taken only in S_IDLE, once the last has left S_FIND; the
// input is accepted while an earlier result still waits on the output, and
// S_FIND stalls only while that result is not yet taken. There is no clearing
// pass: entries above the count are never read.
module indexed_list_store import ils_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side: operation [2:0], index [9:3], value [41:10], zero fill above
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // master side: read_value [31:0], found [32], found_index [38:33],
    // count [45:39], error [47:46]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = $clog2(DEPTH);
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIND
    } t_state;

    t_state                r_state;
    logic [OP_W-1:0]       r_op;
    logic [IDX_W-1:0]      r_idx;
    logic [WORD_WIDTH-1:0] r_val;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [WORD_WIDTH-1:0] r_rd;
    logic [WORD_WIDTH-1:0] n_rd;
    t_err                  r_err;
    t_err                  n_err;

    // output register
    logic                  r_out_valid;
    logic [VAL_W-1:0]      r_o_rd;
    logic                  r_o_found;
    logic [FIDX_W-1:0]     r_o_fidx;
    logic [CNT_W-1:0]      r_o_count;
    t_err                  r_o_err;
    logic                  load_out;

    t_cell_ctl             ctl;
    logic [CMPW-1:0]       idx_x;
    logic [CMPW-1:0]       cnt_x;
    logic                  in_range;

    logic [WORD_WIDTH-1:0] cell_entry [DEPTH];
    logic [WORD_WIDTH-1:0] cell_rd    [DEPTH];
    logic [DEPTH-1:0]      cell_hit;
    logic [WORD_WIDTH-1:0] rd_or;
    logic                  find_found;
    logic [IW-1:0]         find_index;

    assign idx_x    = CMPW'(r_idx);
    assign cnt_x    = CMPW'(r_count);
    assign in_range = (idx_x < cnt_x);

    // row of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_WIDTH-1:0] left;
        logic [WORD_WIDTH-1:0] right;

        if (g == 0) begin : g_first
            assign left = r_val;
        end else begin : g_mid_l
            assign left = cell_entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right = cell_entry[g];
        end else begin : g_mid_r
            assign right = cell_entry[g+1];
        end

        ils_cell #(
            .WORD_WIDTH (WORD_WIDTH),
            .CMPW       (CMPW),
            .POS        (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_idx   (idx_x),
            .i_count (cnt_x),
            .i_value (r_val),
            .i_left  (left),
            .i_right (right),
            .o_entry (cell_entry[g]),
            .o_hit   (cell_hit[g]),
            .o_rd    (cell_rd[g])
        );
    end

    // lowest matching cell
    ils_find #(
        .DEPTH (DEPTH)
    ) u_find (
        .i_hit   (cell_hit),
        .o_found (find_found),
        .o_index (find_index)
    );

    // only the indexed cell drives a nonzero read word
    always_comb begin
        rd_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_or = rd_or | cell_rd[i];
        end
    end

    // decode the request: error check, cell controls, new count
    always_comb begin
        ctl        = '0;
        ctl.exec   = (r_state == S_EXEC);
        n_err      = ERR_OK;
        n_rd       = '0;
        n_count    = r_count;
        case (r_op)
            OP_GET, OP_SET, OP_REMOVE: begin
                if (!in_range) begin
                    n_err = ERR_RANGE;
                end else begin
                    n_rd       = rd_or;
                    ctl.set_en = ctl.exec && (r_op == OP_SET);
                    ctl.rem_en = ctl.exec && (r_op == OP_REMOVE);
                    if (r_op == OP_REMOVE) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            OP_INSERT: begin
                if (idx_x > cnt_x) begin
                    n_err = ERR_RANGE;
                end else if (r_count == CW'(DEPTH)) begin
                    n_err = ERR_FULL;
                end else begin
                    ctl.ins_en = ctl.exec;
                    n_count    = r_count + CW'(1);
                end
            end
            default: begin
                n_err = ERR_OK;
            end
        endcase
    end

    // the output register takes a result when it is empty or being emptied
    assign load_out = (r_state == S_FIND) && (!r_out_valid || m_axis_tready);

    // sequencer, request registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op    <= s_axis_tdata[OP_W-1:0];
                        r_idx   <= s_axis_tdata[OP_W +: IDX_W];
                        r_val   <= WORD_WIDTH'(s_axis_tdata[OP_W+IDX_W +: VAL_W]);
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_count <= n_count;
                    r_rd    <= n_rd;
                    r_err   <= n_err;
                    r_state <= S_FIND;
                end
                S_FIND: begin
                    if (load_out) begin
                        r_o_rd      <= VAL_W'(r_rd);
                        r_o_found   <= (r_op == OP_FIND) && find_found;
                        r_o_fidx    <= ((r_op == OP_FIND) && find_found) ?
                                       FIDX_W'(find_index) : '0;
                        r_o_count   <= CNT_W'(r_count);
                        r_o_err     <= r_err;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_o_err, r_o_count, r_o_fidx, r_o_found, r_o_rd};

    // fill level never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above capacity");

    // a good insert grows the list by one word
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_op == OP_INSERT && n_err == ERR_OK)
        |=> r_count == CW'($past(r_count) + CW'(1)))
        else $error("insert did not grow the list");

    // an error result carries no read word and no find hit
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_err != ERR_OK) |-> (r_o_rd == '0 && !r_o_found))
        else $error("error result with read data or find hit");

endmodule

FILE: bench/indexed_list_store_checker.sv
// indexed_list_store_checker: scoreboard for the indexed list store
// watches both stream channels, keeps its own copy of the list and checks every result word
// depends on ils_pkg
module indexed_list_store_checker import ils_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    // operation [2:0], index [9:3], value [41:10], zero fill above
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    // read_value [31:0], found [32], found_index [38:33], count [45:39], error [47:46]
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_list_len,
    output int                     o_checked,
    output int                     o_full_rejects,
    output int                     o_find_hits
);

    // result word layout, highest field first
    typedef struct packed {
        t_err              error;
        logic [CNT_W-1:0]  count;
        logic [FIDX_W-1:0] found_index;
        logic              found;
        logic [VAL_W-1:0]  read_value;
    } t_list_result;

    // shadow copy of the list
    logic [VAL_W-1:0] list_mem [DEPTH_DEF];
    int               list_len;

    t_list_result     expected_q [$];
    int               fail_count;
    int               checked;
    int               full_rejects;
    int               find_hits;
    int               result_num;

    // apply one request word to the shadow list and return the result it gives
    function automatic t_list_result apply_request(input logic [OP_W-1:0] op, input int idx,
                                                   input logic [VAL_W-1:0] val);
        t_list_result r;
        int           i;
        r = '0;
        case (op)
            OP_GET, OP_SET, OP_REMOVE: begin
                if (idx >= list_len) begin
                    r.error = ERR_RANGE;
                end else begin
                    r.read_value = list_mem[idx];
                    if (op == OP_SET) begin
                        list_mem[idx] = val;
                    end else if (op == OP_REMOVE) begin
                        // close the gap
                        for (i = idx; i < list_len - 1; i++)
                            list_mem[i] = list_mem[i + 1];
                        list_len--;
                    end
                end
            end
            OP_INSERT: begin
                // a bad index is reported ahead of a full list
                if (idx > list_len) begin
                    r.error = ERR_RANGE;
                end else if (list_len >= DEPTH_DEF) begin
                    r.error = ERR_FULL;
                end else begin
                    for (i = list_len; i > idx; i--)
                        list_mem[i] = list_mem[i - 1];
                    list_mem[idx] = val;
                    list_len++;
                end
            end
            OP_FIND: begin
                // lowest matching position wins
                for (i = 0; i < list_len; i++) begin
                    if (!r.found && list_mem[i] == val) begin
                        r.found       = 1'b1;
                        r.found_index = i[FIDX_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        r.count = list_len[CNT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
        if (got !== want) begin
            $error("result word %0d: %s expected 0x%0h, got 0x%0h", result_num, name, want, got);
            fail_count++;
        end
    endtask

    // predict on accepted requests, compare on accepted results
    always @(posedge i_clk) begin
        t_list_result want;
        t_list_result got;
        if (!i_rst_n) begin
            list_len = 0;
            expected_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                want = apply_request(i_s_tdata[OP_W-1:0],
                                     int'(i_s_tdata[OP_W+IDX_W-1:OP_W]),
                                     i_s_tdata[OP_W+IDX_W+VAL_W-1:OP_W+IDX_W]);
                if (want.error == ERR_FULL)
                    full_rejects++;
                if (want.found)
                    find_hits++;
                expected_q.push_back(want);
            end
            if (i_m_tvalid && i_m_tready) begin
                got = t_list_result'(i_m_tdata);
                if (expected_q.size() == 0) begin
                    $error("result word %0d arrived with no request pending", result_num);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("read_value", want.read_value, got.read_value);
                    check_field("found", VAL_W'(want.found), VAL_W'(got.found));
                    check_field("found_index", VAL_W'(want.found_index),
                                VAL_W'(got.found_index));
                    check_field("count", VAL_W'(want.count), VAL_W'(got.count));
                    check_field("error", VAL_W'(want.error), VAL_W'(got.error));
                    checked++;
                end
                result_num++;
            end
        end
        o_fail_count   <= fail_count;
        o_pending      <= expected_q.size();
        o_list_len     <= list_len;
        o_checked      <= checked;
        o_full_rejects <= full_rejects;
        o_find_hits    <= find_hits;
    end

endmodule

FILE: bench/testbench.sv
// testbench: stimulus, stream idling and verdict for indexed_list_store
// depends on ils_pkg, indexed_list_store and indexed_list_store_checker
module testbench;
    import ils_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 650;
    localparam int POOL_SIZE    = 12;

    // operation codes the block does not define
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // operation [2:0], index [9:3], value [41:10], zero fill above
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // read_value [31:0], found [32], found_index [38:33], count [45:39], error [47:46]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending;
    int list_len_hint;
    int checked;
    int full_rejects;
    int find_hits;
    int sent;
    int idle_cycles;

    logic [VAL_W-1:0] key_pool [POOL_SIZE];

    indexed_list_store DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    indexed_list_store_checker list_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_axis_tvalid),
        .i_s_tready     (s_axis_tready),
        .i_s_tdata      (s_axis_tdata),
        .i_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .i_m_tdata      (m_axis_tdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_list_len     (list_len_hint),
        .o_checked      (checked),
        .o_full_rejects (full_rejects),
        .o_find_hits    (find_hits)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    // offer one request word and hold it until accepted
    task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                input logic [VAL_W-1:0] val, input bit calm);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-OP_W-IDX_W-VAL_W){1'b0}}, val, idx, op};
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    // result side back-pressure
    initial begin
        int hold;
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            m_axis_tready <= 1'b1;
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 12);
            repeat (hold) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // end the run if neither channel moves a word for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("indexed_list_store verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        int               n;
        int               r;
        int               len;
        int               limit;
        int               calm_left;
        bit               growing;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (n = 2; n < POOL_SIZE; n++)
            key_pool[n] = $urandom;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list errors, edges of index and value, duplicates
        send_request(OP_GET, 7'd0, 32'h0, 1'b0);
        send_request(OP_REMOVE, 7'd0, 32'h0, 1'b0);
        send_request(OP_SET, 7'd0, 32'h1111_1111, 1'b0);
        send_request(OP_FIND, 7'd0, 32'h0, 1'b0);
        send_request(OP_INSERT, 7'd1, 32'h2222_2222, 1'b0);
        send_request(OP_INSERT, 7'd0, 32'hFFFF_FFFF, 1'b0);
        send_request(OP_INSERT, 7'd1, 32'h0000_0000, 1'b0);
        send_request(OP_INSERT, 7'd0, 32'hA5A5_5A5A, 1'b0);
        send_request(OP_INSERT, 7'd1, 32'h0000_0001, 1'b0);
        send_request(OP_INSERT, 7'd127, 32'h3333_3333, 1'b0);
        send_request(OP_GET, 7'd3, 32'h0, 1'b0);
        send_request(OP_GET, 7'd4, 32'h0, 1'b0);
        send_request(OP_GET, 7'd127, 32'h0, 1'b0);
        send_request(OP_SET, 7'd2, 32'h8000_0000, 1'b0);
        send_request(OP_FIND, 7'd0, 32'hFFFF_FFFF, 1'b0);
        send_request(OP_FIND, 7'd0, 32'h1234_5678, 1'b0);
        send_request(OP_INSERT, 7'd2, 32'hFFFF_FFFF, 1'b0);
        send_request(OP_FIND, 7'd0, 32'hFFFF_FFFF, 1'b0);
        send_request(OP_REMOVE, 7'd0, 32'h0, 1'b0);
        send_request(OP_REMOVE, 7'd3, 32'h0, 1'b0);
        send_request(OP_REMOVE, 7'd64, 32'h0, 1'b0);
        for (n = OP_SPARE_LO; n <= OP_SPARE_HI; n++)
            send_request(n[OP_W-1:0], 7'($urandom_range(0, 127)), $urandom, 1'b0);

        // random: alternate filling to full and draining to empty
        growing   = 1'b1;
        calm_left = 0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            len = list_len_hint;
            if (growing && len >= DEPTH_DEF && $urandom_range(0, 5) == 0)
                growing = 1'b0;
            else if (!growing && len == 0 && $urandom_range(0, 2) == 0)
                growing = 1'b1;

            r = $urandom_range(0, 99);
            if (growing) begin
                if (r < 60)      op = OP_INSERT;
                else if (r < 70) op = OP_GET;
                else if (r < 78) op = OP_SET;
                else if (r < 90) op = OP_FIND;
                else if (r < 97) op = OP_REMOVE;
                else             op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            end else begin
                if (r < 55)      op = OP_REMOVE;
                else if (r < 65) op = OP_INSERT;
                else if (r < 75) op = OP_GET;
                else if (r < 83) op = OP_SET;
                else if (r < 97) op = OP_FIND;
                else             op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            end

            // index: mostly in range, biased to both ends, some out of range
            limit = (op == OP_INSERT) ? len : len - 1;
            r = $urandom_range(0, 99);
            if (r < 5)
                idx = 7'($urandom_range(0, 127));
            else if (r < 15)
                idx = 7'($urandom_range(limit + 1, 127));
            else if (limit < 0)
                idx = '0;
            else if (r < 22)
                idx = '0;
            else if (r < 30)
                idx = 7'(limit);
            else
                idx = 7'($urandom_range(0, limit));

            // reuse a small set of words so finds hit and duplicates appear
            if ($urandom_range(0, 99) < ((op == OP_FIND) ? 60 : 35))
                val = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                val = $urandom;

            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 99) == 0)
                calm_left = $urandom_range(30, 80);

            send_request(op, idx, val, calm_left > 0);
        end
        s_axis_tvalid <= 1'b0;

        // drain outstanding results, then watch for strays
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("sent %0d request words, checked %0d result words", sent, checked);
        $display("full-list rejects %0d, find hits %0d", full_rejects, find_hits);
        if (fail_count == 0)
            $display("indexed_list_store verification clean");
        else
            $display("indexed_list_store verification failed");
        $finish;
    end

endmodule
